// ----- rtl/epst_pkg.sv -----
// Shared constants, widths and types of the encoder position and speed tracker.
`default_nettype none

package epst_pkg;

   // Parameter defaults
   localparam int COUNT_BITS_DEF      = 16;
   localparam int RATIO_FRAC_BITS_DEF = 8;
   localparam int SPEED_FRAC_BITS_DEF = 8;

   // Fixed field widths
   localparam int CPR_W   = 17;
   localparam int DT_W    = 16;
   localparam int RATIO_W = 24;
   localparam int WORD_W  = 32;
   localparam int QUO_W   = 32;

   // Microseconds per minute, the speed scale of rpm against a microsecond interval
   localparam int SCALE_W = 26;
   localparam logic [SCALE_W-1:0] RPM_US_SCALE = SCALE_W'(60000000);

   // Shared multiplier: the widest operands are cpr*dt (33 bits) and the scale
   localparam int MUL_A_W = CPR_W + DT_W;
   localparam int MUL_B_W = SCALE_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Speed divisor cpr*dt*ratio
   localparam int DEN_W = CPR_W + DT_W + RATIO_W;

   // Configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_RATIO     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET    = 2'd2;

   // Register reset values
   localparam logic [CPR_W-1:0]   CPR_RESET   = CPR_W'(4096);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(256);

   // Signed 32-bit limits
   localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

   // Result of the shared divider
   typedef struct packed {
      logic             done;
      logic             ovf;
      logic [QUO_W-1:0] quo;
   } div_res_type;

endpackage

`default_nettype wire

// ----- rtl/epst_if.sv -----
// Request and response channel interfaces of the encoder position and speed tracker.
`default_nettype none

interface epst_req_if #(
   parameter int COUNT_BITS = epst_pkg::COUNT_BITS_DEF
);
   import epst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] raw_count;
   logic [DT_W-1:0]       interval_us;

   modport source (output valid, output raw_count, output interval_us, input ready);
   modport sink   (input valid, input raw_count, input interval_us, output ready);
endinterface

interface epst_rsp_if;
   import epst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] joint_position;
   logic signed [WORD_W-1:0] joint_rpm_q8;
   logic                     speed_valid;
   logic                     sample_taken;

   modport source (output valid, output joint_position, output joint_rpm_q8,
                   output speed_valid, output sample_taken, input ready);
   modport sink   (input valid, input joint_position, input joint_rpm_q8,
                   input speed_valid, input sample_taken, output ready);
endinterface

`default_nettype wire

// ----- rtl/epst_mul.sv -----
// Registered unsigned multiplier shared by the speed datapath.
`default_nettype none

module epst_mul #(
   parameter int A_W = epst_pkg::MUL_A_W,
   parameter int B_W = epst_pkg::MUL_B_W
) (
   input  wire logic               clock,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic      [A_W+B_W-1:0] prod
);
   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W+B_W-1:0] prod_in;

   assign prod_in = {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/epst_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, with early overflow detect.
`default_nettype none

module epst_div #(
   parameter int NUM_W = 59,
   parameter int DEN_W = epst_pkg::DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output epst_pkg::div_res_type res
);
   import epst_pkg::*;

   localparam int HI_W   = NUM_W - QUO_W;
   localparam int STEP_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [HI_W-1:0]   num_hi;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   assign num_hi = num[NUM_W-1:QUO_W];
   assign trial  = {rem_ff, quo_ff[QUO_W-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign ge     = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         den_in = den;
         // quotient of 2^32 or more: flag it and skip the iterations
         if (DEN_W'(num_hi) >= den) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
            rem_in  = DEN_W'(num_hi);
            quo_in  = num[QUO_W-1:0];
            step_in = STEP_W'(QUO_W - 1);
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.ovf  = ovf_ff;
   assign res.quo  = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/encoder_position_speed_tracker.sv -----
// A sample with a nonzero interval runs the position division, the multiplier steps
// and the speed division before its result (fewer steps when the ratio is zero or no
// previous sample exists, and a division ends early on quotient overflow). A zero-interval
// sample answers in the cycle after its transfer with the held values. One sample at a
// time, no new transfer until the result is taken; at most two divider passes of 32 steps.
// Reset (synchronous): clear sequencer and held state; load cpr 4096, ratio 256, offset 0.
`default_nettype none

module encoder_position_speed_tracker #(
   parameter int COUNT_BITS      = epst_pkg::COUNT_BITS_DEF,
   parameter int RATIO_FRAC_BITS = epst_pkg::RATIO_FRAC_BITS_DEF,
   parameter int SPEED_FRAC_BITS = epst_pkg::SPEED_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   epst_req_if.sink                                req,
   epst_rsp_if.source                              rsp,
   input  wire logic                               csr_we,
   input  wire logic [epst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [epst_pkg::WORD_W-1:0]        csr_wdata
);
   import epst_pkg::*;

   // Dividend width: |delta| * scale, shifted up by both fraction widths
   localparam int NUM_W = COUNT_BITS + 1 + SCALE_W + SPEED_FRAC_BITS + RATIO_FRAC_BITS;
   // Width of the signed delta before and after the wrap fold
   localparam int DLW   = ((COUNT_BITS > CPR_W) ? COUNT_BITS : CPR_W) + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_DIV,
      ST_POS_WAIT,
      ST_SPD_SEL,
      ST_MUL_CD,
      ST_MUL_DEN,
      ST_MUL_NUM,
      ST_SPD_DIV,
      ST_SPD_WAIT,
      ST_RESP
   } state_type;

   // Configuration registers
   logic [CPR_W-1:0]          cpr_ff;
   logic [RATIO_W-1:0]        ratio_ff;
   logic signed [WORD_W-1:0]  offset_ff;

   // Sequencer and datapath registers
   state_type                 state_ff, state_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic [COUNT_BITS:0]       mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [COUNT_BITS-1:0]     prev_ff, prev_in;
   logic                      has_sample_ff, has_sample_in;
   logic signed [WORD_W-1:0]  pos_ff, pos_in;
   logic signed [WORD_W-1:0]  spd_ff, spd_in;
   logic                      fresh_ff, fresh_in;
   logic                      taken_ff, taken_in;

   // Wrap fold of the count delta
   logic signed [DLW-1:0]     delta;
   logic signed [DLW-1:0]     half_s;
   logic signed [DLW-1:0]     cpr_s;
   logic signed [DLW-1:0]     folded;
   logic signed [DLW-1:0]     folded_abs;

   // Shared units
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [MUL_P_W-1:0]        mul_p;
   logic                      div_start;
   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   div_res_type               div_res;

   // Result shaping
   logic signed [WORD_W+1:0]  pos_diff;
   logic signed [WORD_W-1:0]  pos_sat;
   logic signed [WORD_W-1:0]  spd_sat;
   logic                      accept;

   epst_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_p)
   );

   epst_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   // Configuration writes; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff    <= CPR_RESET;
         ratio_ff  <= RATIO_RESET;
         offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNTS_PER_REV: cpr_ff    <= csr_wdata[CPR_W-1:0];
            CSR_GEAR_RATIO:     ratio_ff  <= csr_wdata[RATIO_W-1:0];
            CSR_ZERO_OFFSET:    offset_ff <= signed'(csr_wdata);
            default:            ;
         endcase
      end
   end

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // Fold the delta into plus or minus half a revolution
   always_comb begin
      delta  = signed'(DLW'(req.raw_count)) - signed'(DLW'(prev_ff));
      half_s = signed'(DLW'(cpr_ff >> 1));
      cpr_s  = signed'(DLW'(cpr_ff));
      if (delta > half_s) begin
         folded = delta - cpr_s;
      end else if (delta < -half_s) begin
         folded = delta + cpr_s;
      end else begin
         folded = delta;
      end
      folded_abs = folded[DLW-1] ? -folded : folded;
   end

   // Multiplier operands: cpr*dt, then (cpr*dt)*ratio, then |delta|*scale
   always_comb begin
      case (state_ff)
         ST_MUL_CD: begin
            mul_a = MUL_A_W'(cpr_ff);
            mul_b = MUL_B_W'(dt_ff);
         end
         ST_MUL_DEN: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = MUL_B_W'(ratio_ff);
         end
         default: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = RPM_US_SCALE;
         end
      endcase
   end

   // Divider: position is (count << R) / ratio, speed is (|delta|*scale << (S+R)) / den
   assign div_start = ((state_ff == ST_POS_DIV) && (ratio_ff != '0)) ||
                      (state_ff == ST_SPD_DIV);
   assign div_num   = (state_ff == ST_SPD_DIV)
                      ? (NUM_W'(mul_p[COUNT_BITS+SCALE_W:0]) <<
                         (SPEED_FRAC_BITS + RATIO_FRAC_BITS))
                      : (NUM_W'(count_ff) << RATIO_FRAC_BITS);
   assign div_den   = (state_ff == ST_SPD_DIV) ? den_ff : DEN_W'(ratio_ff);

   // Position: quotient minus offset, saturated; a quotient of 2^32 or more is past max
   always_comb begin
      pos_diff = signed'({2'b00, div_res.quo}) - (WORD_W+2)'(offset_ff);
      if (div_res.ovf || (pos_diff > (WORD_W+2)'(S32_MAX))) begin
         pos_sat = S32_MAX;
      end else if (pos_diff < (WORD_W+2)'(S32_MIN)) begin
         pos_sat = S32_MIN;
      end else begin
         pos_sat = pos_diff[WORD_W-1:0];
      end
   end

   // Speed: apply the sign, saturate the magnitude
   always_comb begin
      if (!neg_ff) begin
         spd_sat = (div_res.ovf || div_res.quo[QUO_W-1]) ? S32_MAX : signed'(div_res.quo);
      end else if (div_res.ovf || (div_res.quo > NEG_LIMIT)) begin
         spd_sat = S32_MIN;
      end else begin
         spd_sat = signed'(~div_res.quo + QUO_W'(1));
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dt_in         = dt_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      den_in        = den_ff;
      prev_in       = prev_ff;
      has_sample_in = has_sample_ff;
      pos_in        = pos_ff;
      spd_in        = spd_ff;
      fresh_in      = fresh_ff;
      taken_in      = taken_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.interval_us == '0) begin
                  // ignore the sample, answer with held values
                  fresh_in = has_sample_ff;
                  taken_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  count_in = req.raw_count;
                  dt_in    = req.interval_us;
                  mag_in   = folded_abs[COUNT_BITS:0];
                  neg_in   = folded[DLW-1];
                  fresh_in = 1'b0;
                  taken_in = 1'b1;
                  state_in = ST_POS_DIV;
               end
            end
         end
         ST_POS_DIV: begin
            if (ratio_ff == '0) begin
               // no conversion: raw count, no offset
               pos_in   = signed'(WORD_W'(count_ff));
               state_in = ST_SPD_SEL;
            end else begin
               state_in = ST_POS_WAIT;
            end
         end
         ST_POS_WAIT: begin
            if (div_res.done) begin
               pos_in   = pos_sat;
               state_in = ST_SPD_SEL;
            end
         end
         ST_SPD_SEL: begin
            prev_in       = count_ff;
            has_sample_in = 1'b1;
            if (!has_sample_ff) begin
               // first sample: keep the held speed
               state_in = ST_RESP;
            end else begin
               fresh_in = 1'b1;
               if (cpr_ff == '0) begin
                  spd_in   = '0;
                  state_in = ST_RESP;
               end else if (ratio_ff == '0) begin
                  if (mag_ff == '0) begin
                     spd_in = '0;
                  end else begin
                     spd_in = neg_ff ? S32_MIN : S32_MAX;
                  end
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_MUL_CD;
               end
            end
         end
         ST_MUL_CD: begin
            state_in = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            state_in = ST_MUL_NUM;
         end
         ST_MUL_NUM: begin
            // product now holds cpr*dt*ratio
            den_in   = mul_p[DEN_W-1:0];
            state_in = ST_SPD_DIV;
         end
         ST_SPD_DIV: begin
            state_in = ST_SPD_WAIT;
         end
         ST_SPD_WAIT: begin
            if (div_res.done) begin
               spd_in   = spd_sat;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // hold the result until the transfer
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         has_sample_ff <= 1'b0;
         prev_ff       <= '0;
         pos_ff        <= '0;
         spd_ff        <= '0;
         fresh_ff      <= 1'b0;
         taken_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         has_sample_ff <= has_sample_in;
         prev_ff       <= prev_in;
         pos_ff        <= pos_in;
         spd_ff        <= spd_in;
         fresh_ff      <= fresh_in;
         taken_ff      <= taken_in;
      end
      count_ff <= count_in;
      dt_ff    <= dt_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
   end

   assign rsp.valid          = (state_ff == ST_RESP);
   assign rsp.joint_position = pos_ff;
   assign rsp.joint_rpm_q8   = spd_ff;
   assign rsp.speed_valid    = fresh_ff;
   assign rsp.sample_taken   = taken_ff;

endmodule

`default_nettype wire

// ----- bench/encoder_position_speed_tracker_tb.sv -----
// Self-checking bench for the encoder position and speed tracker: directed plan plus random motion.
module encoder_position_speed_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import epst_pkg::*;

   // Run shape
   localparam int unsigned PHASES          = 10;
   localparam int unsigned ITEMS_PER_PHASE = 168;
   localparam int unsigned PHASE_SETTLE    = 4;       // idle cycles before a register write
   localparam int unsigned END_SETTLE      = 100;     // idle cycles after the last result
   localparam int unsigned CYCLE_LIMIT     = 1_200_000;
   localparam int unsigned HOLD_OFF_AT     = 20_000;  // receiver cycles before the long stall
   localparam int unsigned HOLD_OFF_LEN    = 600;
   localparam longint unsigned US_PER_MIN  = 64'd60_000_000;

   // One tracker result: what the block reports for one transfer in
   typedef struct packed {
      logic signed [WORD_W-1:0] pos;
      logic signed [WORD_W-1:0] rpm;
      logic                     fresh;
      logic                     taken;
   } track_out_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} plan_kind_type;

   typedef struct {
      plan_kind_type        kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [WORD_W-1:0]    value;
      logic [15:0]          count;
      logic [DT_W-1:0]      dt;
      bit                   known;
      track_out_type        want;
   } plan_row_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   epst_req_if req ();
   epst_rsp_if rsp ();

   encoder_position_speed_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Tracker copy: registers and sample history as the block should hold them
   logic [CPR_W-1:0]         cfg_cpr    = CPR_RESET;
   logic [RATIO_W-1:0]       cfg_ratio  = RATIO_RESET;
   logic signed [WORD_W-1:0] cfg_offset = '0;
   logic [15:0]              prev_count = '0;
   logic                     has_sample = 1'b0;
   logic signed [WORD_W-1:0] held_pos   = '0;
   logic signed [WORD_W-1:0] held_rpm   = '0;

   // Readings still owed by the block, oldest first
   track_out_type pending_readings[$];
   track_out_type want_now;

   plan_row_type plan[$];
   int unsigned  mismatches    = 0;
   int unsigned  results_seen  = 0;
   int unsigned  samples_taken = 0;
   int unsigned  burst_left    = 0;
   int unsigned  cycles        = 0;
   bit           offering      = 0;

   // Clock: 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic signed [WORD_W-1:0] sat_word(longint v);
      if (v > longint'(S32_MAX))
         return S32_MAX;
      if (v < longint'(S32_MIN))
         return S32_MIN;
      return v[WORD_W-1:0];
   endfunction

   // Advance the tracker copy by one accepted sample and return the reading it owes.
   function automatic track_out_type advance_tracker(logic [15:0] count, logic [DT_W-1:0] dt);
      track_out_type      r;
      longint             cnt     = count;
      longint             prev_l  = prev_count;
      longint             cpr_l   = cfg_cpr;
      longint             ratio_l = cfg_ratio;
      longint             dt_l    = dt;
      longint             off_l   = cfg_offset;
      longint             delta, half_rev, quo;
      longint unsigned    mag, num, den;
      // speed_valid reflects history before this sample in both branches
      r.fresh = has_sample;
      r.taken = (dt != 0);
      if (dt != 0) begin
         // Zero ratio: raw count straight through, offset ignored
         if (ratio_l == 0)
            held_pos = cnt[WORD_W-1:0];
         else
            held_pos = sat_word(((cnt << RATIO_FRAC_BITS_DEF) / ratio_l) - off_l);
         if (has_sample) begin
            // Fold the change into plus or minus half a revolution
            delta    = cnt - prev_l;
            half_rev = cpr_l / 2;
            if (delta > half_rev)
               delta = delta - cpr_l;
            else if (delta < -half_rev)
               delta = delta + cpr_l;
            if (cpr_l == 0)
               held_rpm = '0;
            else if (ratio_l == 0)
               held_rpm = (delta > 0) ? S32_MAX : ((delta < 0) ? S32_MIN : '0);
            else begin
               // Truncated quotient of |delta|*60e6*2^(S+R) / (cpr*dt*ratio)
               mag = (delta < 0) ? -delta : delta;
               num = (mag * US_PER_MIN) << (SPEED_FRAC_BITS_DEF + RATIO_FRAC_BITS_DEF);
               den = cpr_l * dt_l * ratio_l;
               quo = longint'(num / den);
               held_rpm = sat_word((delta < 0) ? -quo : quo);
            end
         end
         prev_count = count;
         has_sample = 1'b1;
      end
      r.pos = held_pos;
      r.rpm = held_rpm;
      return r;
   endfunction

   function automatic void plan_write(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      plan_row_type row;
      row         = '{kind: ROW_WRITE, default: '0};
      row.reg_idx = idx;
      row.value   = value;
      plan.push_back(row);
   endfunction

   function automatic void plan_sample(logic [15:0] count, logic [DT_W-1:0] dt);
      plan_row_type row;
      row       = '{kind: ROW_SAMPLE, default: '0};
      row.count = count;
      row.dt    = dt;
      plan.push_back(row);
   endfunction

   // Sample whose reading is typed in here rather than taken from the tracker copy
   function automatic void plan_known(logic [15:0] count, logic [DT_W-1:0] dt,
                                      logic signed [WORD_W-1:0] pos,
                                      logic signed [WORD_W-1:0] rpm,
                                      logic fresh, logic taken);
      plan_row_type row;
      row            = '{kind: ROW_SAMPLE, default: '0};
      row.count      = count;
      row.dt         = dt;
      row.known      = 1'b1;
      row.want.pos   = pos;
      row.want.rpm   = rpm;
      row.want.fresh = fresh;
      row.want.taken = taken;
      plan.push_back(row);
   endfunction

   // Sender bursts: mostly short runs, now and then a long run with no gaps at all
   function automatic int unsigned next_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 12);
      // Long gaps let valid rise at any point of the block's computation
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 15);
   endfunction

   task automatic report_mismatch(string field, logic signed [WORD_W-1:0] got,
                                  logic signed [WORD_W-1:0] want);
      mismatches++;
      $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
   endtask

   // Drop valid, unless it is already low
   task automatic idle_input();
      if (offering) begin
         req.valid <= 1'b0;
         offering = 0;
      end
   endtask

   task automatic pause(int unsigned gap);
      if (gap != 0) begin
         idle_input();
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every owed reading has come back, then let the block sit idle a while
   task automatic drain_results(int unsigned settle);
      idle_input();
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write one register and mirror it in the tracker copy
   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_COUNTS_PER_REV: cfg_cpr    = value[CPR_W-1:0];
         CSR_GEAR_RATIO:     cfg_ratio  = value[RATIO_W-1:0];
         CSR_ZERO_OFFSET:    cfg_offset = value;
         default: ;
      endcase
   endtask

   // Offer one sample and hold it until the transfer; then log the reading it owes
   task automatic offer_sample(logic [15:0] count, logic [DT_W-1:0] dt, bit known,
                               track_out_type known_want);
      track_out_type predicted;
      req.valid       <= 1'b1;
      req.raw_count   <= count;
      req.interval_us <= dt;
      offering = 1;
      do
         @(posedge clock);
      while (!req.ready);
      predicted = advance_tracker(count, dt);
      pending_readings.push_back(known ? known_want : predicted);
      if (dt != 0)
         samples_taken++;
   endtask

   // Stimulus: reset, directed plan, then random phases of encoder motion
   initial begin : stimulus
      int unsigned       ph, phase_start, pick, dt_pick;
      logic [WORD_W-1:0] cpr_val, ratio_val, offset_val;
      logic [15:0]       count;
      logic [DT_W-1:0]   dt;
      longint            span, half_rev, move, next_count;

      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_COUNTS_PER_REV;
      csr_wdata       <= '0;
      req.valid       <= 1'b0;
      req.raw_count   <= '0;
      req.interval_us <= '0;

      // Reset registers: cpr 4096, ratio 1.0, offset 0
      plan_known(16'h0064, 16'h0000, 32'sd0, 32'sd0, 1'b0, 1'b0);    // zero interval, no history
      plan_known(16'h0000, 16'h0001, 32'sd0, 32'sd0, 1'b0, 1'b1);    // first sample keeps speed
      plan_sample(16'hFFFF, 16'hFFFF);
      plan_sample(16'hFFFF, 16'h0000);                               // zero interval with history
      plan_known(16'hFFFF, 16'h0001, 32'sd65535, 32'sd0, 1'b1, 1'b1); // no motion
      plan_known(16'h0000, 16'h0001, 32'sd0, S32_MIN, 1'b1, 1'b1);  // folded, saturates low
      plan_sample(16'h0800, 16'hFFFF);                               // delta exactly +half
      plan_sample(16'h0000, 16'd1000);                               // delta exactly -half
      plan_sample(16'h0801, 16'd7);                                  // one past half, folds
      plan_sample(16'h5555, 16'hAAAA);
      plan_sample(16'hAAAA, 16'h5555);
      // Zero ratio: count passes straight through, speed goes to a rail when the count moves
      plan_write(CSR_GEAR_RATIO, 32'd0);
      plan_known(16'd1000, 16'd10, 32'sd1000, S32_MIN, 1'b1, 1'b1);
      plan_known(16'd1000, 16'd10, 32'sd1000, 32'sd0, 1'b1, 1'b1);
      plan_known(16'd1100, 16'd10, 32'sd1100, S32_MAX, 1'b1, 1'b1);
      plan_write(CSR_ZERO_OFFSET, S32_MIN);
      plan_known(16'd5, 16'd3, 32'sd5, S32_MIN, 1'b1, 1'b1);        // offset ignored
      // Largest ratio with the most negative offset: position saturates high, no motion
      plan_write(CSR_GEAR_RATIO, 32'h00FF_FFFF);
      plan_known(16'h0005, 16'h0001, S32_MAX, 32'sd0, 1'b1, 1'b1);
      plan_write(CSR_ZERO_OFFSET, S32_MAX);
      plan_sample(16'h0000, 16'hFFFF);
      plan_write(CSR_GEAR_RATIO, 32'd1);
      plan_sample(16'hFFFF, 16'hFFFF);
      // Zero counts per rev: no folding, speed zero
      plan_write(CSR_COUNTS_PER_REV, 32'd0);
      plan_known(16'h0000, 16'hFFFF, S32_MIN + 32'sd1, 32'sd0, 1'b1, 1'b1);
      plan_write(CSR_COUNTS_PER_REV, 32'd1);
      plan_sample(16'h0001, 16'h0001);
      plan_sample(16'h0000, 16'h0001);
      plan_write(CSR_COUNTS_PER_REV, 32'h0001_0000);
      plan_sample(16'hFFFF, 16'h0001);
      plan_write(CSR_COUNTS_PER_REV, 32'h0001_FFFF);
      plan_sample(16'h0000, 16'h0001);
      plan_sample(16'h0001, 16'hFFFF);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the plan; register writes only once the block has gone quiet
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_results(PHASE_SETTLE);
            set_reg(plan[i].reg_idx, plan[i].value);
         end else begin
            offer_sample(plan[i].count, plan[i].dt, plan[i].known, plan[i].want);
            pause(next_gap());
         end
      end

      // Random phases, each with its own register setting, extremes first
      for (ph = 0; ph < PHASES; ph++) begin
         drain_results(PHASE_SETTLE);
         case (ph)
            0: begin
               cpr_val = 32'd4096;       ratio_val = 32'd256;        offset_val = 32'd0;
            end
            1: begin
               cpr_val = 32'd1;          ratio_val = 32'd1;          offset_val = S32_MAX;
            end
            2: begin
               cpr_val = 32'h0001_0000;  ratio_val = 32'h00FF_FFFF;  offset_val = S32_MIN;
            end
            3: begin
               cpr_val = 32'd0;          ratio_val = $urandom_range(1, 32'h00FF_FFFF);
               offset_val = $urandom;
            end
            4: begin
               cpr_val = 32'h0001_FFFF;  ratio_val = 32'd0;          offset_val = $urandom;
            end
            5: begin
               cpr_val = 32'd2;          ratio_val = 32'd256;
               offset_val = $urandom_range(0, 2000) - 1000;
            end
            default: begin
               cpr_val    = $urandom_range(0, 1) ? $urandom_range(1, 65536)
                                                 : $urandom_range(100, 5000);
               ratio_val  = $urandom_range(0, 1) ? $urandom_range(0, 32'h00FF_FFFF)
                                                 : $urandom_range(64, 25600);
               offset_val = $urandom_range(0, 1) ? $urandom
                                                 : $urandom_range(0, 20000) - 10000;
            end
         endcase
         set_reg(CSR_COUNTS_PER_REV, cpr_val);
         set_reg(CSR_GEAR_RATIO, ratio_val);
         set_reg(CSR_ZERO_OFFSET, offset_val);

         // Ignored zero-interval samples do not count toward the phase
         phase_start = samples_taken;
         while (samples_taken - phase_start < ITEMS_PER_PHASE) begin
            // Counts wrap at the revolution, as a real encoder would
            span     = (cfg_cpr != 0 && cfg_cpr <= 65536) ? cfg_cpr : 65536;
            half_rev = cfg_cpr / 2;
            pick     = $urandom_range(0, 19);
            if (pick < 2)
               count = 16'($urandom);                     // noise: any count at all
            else begin
               if (pick < 4)
                  move = half_rev + int'($urandom_range(0, 2)) - 1;  // around the fold
               else if (pick < 8)
                  move = $urandom_range(0, span / 4 + 1);            // fast motion
               else
                  move = $urandom_range(0, 40);                      // slow motion
               if ($urandom_range(0, 1))
                  move = -move;
               next_count = (longint'(prev_count) + move) % span;
               if (next_count < 0)
                  next_count = next_count + span;
               count = next_count[15:0];
            end
            dt_pick = $urandom_range(0, 15);
            if (dt_pick == 0)
               dt = '0;
            else if (dt_pick == 1)
               dt = 16'h0001;
            else if (dt_pick == 2)
               dt = 16'hFFFF;
            else if (dt_pick < 6)
               dt = DT_W'($urandom);
            else
               dt = DT_W'($urandom_range(10, 4000));
            offer_sample(count, dt, 1'b0, '0);
            pause(next_gap());
         end
      end

      drain_results(END_SETTLE);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Receiver: ready in runs with short stalls, plus one long hold-off that backs
   // the block up while the sender keeps offering
   initial begin : rsp_stall_pattern
      int unsigned run_len, stall_len, rx_cycles;
      bit          held_off;
      rx_cycles = 0;
      held_off  = 0;
      rsp.ready <= 1'b0;
      do
         @(posedge clock);
      while (reset);
      forever begin
         run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                 : $urandom_range(1, 30);
         stall_len = $urandom_range(1, 12);
         if (!held_off && rx_cycles > HOLD_OFF_AT) begin
            stall_len = HOLD_OFF_LEN;
            held_off  = 1;
         end
         rsp.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         rsp.ready <= 1'b0;
         repeat (stall_len) @(posedge clock);
         rx_cycles += run_len + stall_len;
      end
   end

   // Check every result transfer against the oldest owed reading, field by field
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0)
            report_mismatch("unexpected result, joint_position", rsp.joint_position, '0);
         else begin
            want_now = pending_readings.pop_front();
            if (rsp.joint_position !== want_now.pos)
               report_mismatch("joint_position", rsp.joint_position, want_now.pos);
            if (rsp.joint_rpm_q8 !== want_now.rpm)
               report_mismatch("joint_rpm_q8", rsp.joint_rpm_q8, want_now.rpm);
            if (rsp.speed_valid !== want_now.fresh)
               report_mismatch("speed_valid", WORD_W'(rsp.speed_valid),
                               WORD_W'(want_now.fresh));
            if (rsp.sample_taken !== want_now.taken)
               report_mismatch("sample_taken", WORD_W'(rsp.sample_taken),
                               WORD_W'(want_now.taken));
         end
         results_seen++;
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
